@@ hdl/quaternion_rotate_vector_top_macros.svh @@
// ---------------------------------------------------------------------------
// quaternion_rotate_vector_top_macros - assertion macros
// Concurrent check wrappers; compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qrv check failed");
// next-cycle implication
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qrv check failed");
`else
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/qrv_pkg.sv @@
// ---------------------------------------------------------------------------
// qrv_pkg - quaternion rotation types and constants
// Field widths, intermediate word types and fixed-point constants.
// ---------------------------------------------------------------------------
package qrv_pkg;

    localparam int QW = 16;     // quaternion part, Q2.14
    localparam int PW = 32;     // point coordinate, Q16.16
    localparam int MW = 36;     // matrix entry, Q.28
    localparam int HW = 54;     // row sum of m * point_hi
    localparam int LW = 55;     // row sum of m * point_lo plus rounding
    localparam int SW = 72;     // full row sum, Q.44
    localparam int RW = SW - 28; // row sum after shift to Q16.16

    typedef logic signed [2*QW-1:0]   t_qprod;
    typedef logic signed [MW-1:0]     t_mat;
    typedef logic signed [PW-1:0]     t_point;
    typedef logic signed [MW+QW-1:0]  t_pp_hi;
    typedef logic signed [MW+QW:0]    t_pp_lo;
    typedef logic signed [HW-1:0]     t_sum_hi;
    typedef logic signed [LW-1:0]     t_sum_lo;

    localparam t_mat    ONE_Q28  = 36'sd268435456;
    localparam t_sum_lo HALF_LSB = 55'sd134217728;   // 2^27, half of Q.44 -> Q16.16 step

endpackage

@@ hdl/quaternion_rotate_vector_top.sv @@
// ---------------------------------------------------------------------------
// quaternion_rotate_vector_top - rotate a Q16.16 point by a Q2.14 quaternion
// Five register stages from accepted item to o_out_valid; one item per cycle
// while i_out_stall is low; stall bubbles are squeezed out stage by stage.
// Reset: synchronous active-low i_rst_n empties all stages; no other state.
// ---------------------------------------------------------------------------
`include "quaternion_rotate_vector_top_macros.svh"

module quaternion_rotate_vector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [qrv_pkg::QW-1:0]    i_quat_x,
    input  logic signed [qrv_pkg::QW-1:0]    i_quat_y,
    input  logic signed [qrv_pkg::QW-1:0]    i_quat_z,
    input  logic signed [qrv_pkg::QW-1:0]    i_quat_w,
    input  logic signed [qrv_pkg::PW-1:0]    i_point_x,
    input  logic signed [qrv_pkg::PW-1:0]    i_point_y,
    input  logic signed [qrv_pkg::PW-1:0]    i_point_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [qrv_pkg::PW-1:0]    o_rotated_x,
    output logic signed [qrv_pkg::PW-1:0]    o_rotated_y,
    output logic signed [qrv_pkg::PW-1:0]    o_rotated_z,
    output logic                             o_clipped
);

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || !i_out_stall;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: pairwise quaternion products
    qrv_pkg::t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qrv_pkg::t_point r_p1 [3];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_xx    <= i_quat_x * i_quat_x;
            r_yy    <= i_quat_y * i_quat_y;
            r_zz    <= i_quat_z * i_quat_z;
            r_xy    <= i_quat_x * i_quat_y;
            r_xz    <= i_quat_x * i_quat_z;
            r_yz    <= i_quat_y * i_quat_z;
            r_wx    <= i_quat_w * i_quat_x;
            r_wy    <= i_quat_w * i_quat_y;
            r_wz    <= i_quat_w * i_quat_z;
            r_p1[0] <= i_point_x;
            r_p1[1] <= i_point_y;
            r_p1[2] <= i_point_z;
        end
    end

    // ---------------- stage 2: rotation matrix, Q.28
    qrv_pkg::t_mat e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    qrv_pkg::t_mat n_m [3][3];
    qrv_pkg::t_mat r_m [3][3];
    qrv_pkg::t_point r_p2 [3];

    localparam int XW = qrv_pkg::MW - 2 * qrv_pkg::QW;

    assign e_xx = {{XW{r_xx[2*qrv_pkg::QW-1]}}, r_xx};
    assign e_yy = {{XW{r_yy[2*qrv_pkg::QW-1]}}, r_yy};
    assign e_zz = {{XW{r_zz[2*qrv_pkg::QW-1]}}, r_zz};
    assign e_xy = {{XW{r_xy[2*qrv_pkg::QW-1]}}, r_xy};
    assign e_xz = {{XW{r_xz[2*qrv_pkg::QW-1]}}, r_xz};
    assign e_yz = {{XW{r_yz[2*qrv_pkg::QW-1]}}, r_yz};
    assign e_wx = {{XW{r_wx[2*qrv_pkg::QW-1]}}, r_wx};
    assign e_wy = {{XW{r_wy[2*qrv_pkg::QW-1]}}, r_wy};
    assign e_wz = {{XW{r_wz[2*qrv_pkg::QW-1]}}, r_wz};

    always_comb begin
        n_m[0][0] = qrv_pkg::ONE_Q28 - ((e_yy + e_zz) <<< 1);
        n_m[0][1] = (e_xy - e_wz) <<< 1;
        n_m[0][2] = (e_xz + e_wy) <<< 1;
        n_m[1][0] = (e_xy + e_wz) <<< 1;
        n_m[1][1] = qrv_pkg::ONE_Q28 - ((e_xx + e_zz) <<< 1);
        n_m[1][2] = (e_yz - e_wx) <<< 1;
        n_m[2][0] = (e_xz - e_wy) <<< 1;
        n_m[2][1] = (e_yz + e_wx) <<< 1;
        n_m[2][2] = qrv_pkg::ONE_Q28 - ((e_xx + e_yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_m  <= n_m;
            r_p2 <= r_p1;
        end
    end

    // ---------------- stage 3: partial products, point split 16/16
    // point = hi * 2^16 + lo, hi signed, lo unsigned
    qrv_pkg::t_pp_hi r_pph [3][3];
    qrv_pkg::t_pp_lo r_ppl [3][3];
    logic signed [qrv_pkg::PW/2-1:0] p_hi [3];
    logic signed [qrv_pkg::PW/2:0]   p_lo [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p_hi[c] = r_p2[c][qrv_pkg::PW-1:qrv_pkg::PW/2];
            p_lo[c] = {1'b0, r_p2[c][qrv_pkg::PW/2-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pph[r][c] <= r_m[r][c] * p_hi[c];
                    r_ppl[r][c] <= r_m[r][c] * p_lo[c];
                end
            end
        end
    end

    // ---------------- stage 4: per-row sums, rounding half folded into lo
    localparam int HX = qrv_pkg::HW - (qrv_pkg::MW + qrv_pkg::QW);
    localparam int LX = qrv_pkg::LW - (qrv_pkg::MW + qrv_pkg::QW + 1);

    qrv_pkg::t_sum_hi r_sh [3];
    qrv_pkg::t_sum_lo r_sl [3];
    qrv_pkg::t_sum_hi n_sh [3];
    qrv_pkg::t_sum_lo n_sl [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sh[r] = qrv_pkg::t_sum_hi'({{HX{r_pph[r][0][qrv_pkg::MW+qrv_pkg::QW-1]}},
                                         r_pph[r][0]})
                    + qrv_pkg::t_sum_hi'({{HX{r_pph[r][1][qrv_pkg::MW+qrv_pkg::QW-1]}},
                                         r_pph[r][1]})
                    + qrv_pkg::t_sum_hi'({{HX{r_pph[r][2][qrv_pkg::MW+qrv_pkg::QW-1]}},
                                         r_pph[r][2]});
            n_sl[r] = qrv_pkg::t_sum_lo'({{LX{r_ppl[r][0][qrv_pkg::MW+qrv_pkg::QW]}},
                                         r_ppl[r][0]})
                    + qrv_pkg::t_sum_lo'({{LX{r_ppl[r][1][qrv_pkg::MW+qrv_pkg::QW]}},
                                         r_ppl[r][1]})
                    + qrv_pkg::t_sum_lo'({{LX{r_ppl[r][2][qrv_pkg::MW+qrv_pkg::QW]}},
                                         r_ppl[r][2]})
                    + qrv_pkg::HALF_LSB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_sh <= n_sh;
            r_sl <= n_sl;
        end
    end

    // ---------------- stage 5: combine, floor-shift to Q16.16, saturate
    localparam int SHX = qrv_pkg::SW - qrv_pkg::HW - qrv_pkg::PW / 2;
    localparam int SLX = qrv_pkg::SW - qrv_pkg::LW;

    logic signed [qrv_pkg::SW-1:0] s_full [3];
    logic signed [qrv_pkg::RW-1:0] s_rnd  [3];
    logic                          ovf_p  [3];
    logic                          ovf_n  [3];
    qrv_pkg::t_point               n_rot  [3];
    logic                          n_clip;
    qrv_pkg::t_point               r_rot  [3];
    logic                          r_clip;

    always_comb begin
        n_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            s_full[r] = {{SHX{r_sh[r][qrv_pkg::HW-1]}}, r_sh[r], {(qrv_pkg::PW/2){1'b0}}}
                      + {{SLX{r_sl[r][qrv_pkg::LW-1]}}, r_sl[r]};
            s_rnd[r]  = s_full[r][qrv_pkg::SW-1:28];
            // anything above bit 31 that is not a pure sign extension overflows
            ovf_p[r]  = !s_rnd[r][qrv_pkg::RW-1] && (|s_rnd[r][qrv_pkg::RW-2:qrv_pkg::PW-1]);
            ovf_n[r]  = s_rnd[r][qrv_pkg::RW-1] && !(&s_rnd[r][qrv_pkg::RW-2:qrv_pkg::PW-1]);
            if (ovf_p[r]) begin
                n_rot[r] = {1'b0, {(qrv_pkg::PW-1){1'b1}}};
            end else if (ovf_n[r]) begin
                n_rot[r] = {1'b1, {(qrv_pkg::PW-1){1'b0}}};
            end else begin
                n_rot[r] = s_rnd[r][qrv_pkg::PW-1:0];
            end
            n_clip = n_clip || ovf_p[r] || ovf_n[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_rot  <= n_rot;
            r_clip <= n_clip;
        end
    end

    assign o_out_valid = r_v5;
    assign o_rotated_x = r_rot[0];
    assign o_rotated_y = r_rot[1];
    assign o_rotated_z = r_rot[2];
    assign o_clipped   = r_clip;

    // ---------------- checks
    `QRV_ASSERT_IMP(a_clip_at_bound, i_clk, i_rst_n, o_out_valid && o_clipped, o_rotated_x == 32'sh7fffffff || o_rotated_x == 32'sh80000000 || o_rotated_y == 32'sh7fffffff || o_rotated_y == 32'sh80000000 || o_rotated_z == 32'sh7fffffff || o_rotated_z == 32'sh80000000)
    `QRV_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall)
    `QRV_ASSERT_NXT(a_stage4_moves, i_clk, i_rst_n, r_v4 && en5, r_v5)

endmodule
